// ----- design/sdcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcb_pkg
// shared types, constants and character helpers for the serial debug bridge
// ----------------------------------------------------------------------------
package sdcb_pkg;

    localparam int ADDRESS_DIGITS_DEF = 2;
    localparam int VALUE_DIGITS_DEF   = 3;
    localparam int ADDR_POS           = 2;

    localparam int ADDR_W = 16;
    localparam int VALUE_W = 8;

    // result kinds on the output channel
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // input command codes
    localparam logic CMD_RX_BYTE   = 1'b0;
    localparam logic CMD_READ_DATA = 1'b1;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_PROMPT = 8'h3E;
    localparam logic [7:0] CHAR_W_UP   = 8'h57;
    localparam logic [7:0] CHAR_W_LO   = 8'h77;
    localparam logic [7:0] CHAR_R_UP   = 8'h52;
    localparam logic [7:0] CHAR_R_LO   = 8'h72;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;

    typedef enum logic {
        JOB_READ_DATA,
        JOB_FRAME
    } t_job;

    typedef enum logic [1:0] {
        DIR_READ,
        DIR_WRITE,
        DIR_OTHER
    } t_dir;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic t_dir dir_class(input logic [7:0] c);
        if ((c == CHAR_R_UP) || (c == CHAR_R_LO)) begin
            return DIR_READ;
        end else if ((c == CHAR_W_UP) || (c == CHAR_W_LO)) begin
            return DIR_WRITE;
        end
        return DIR_OTHER;
    endfunction

endpackage

// ----- design/sdcb_atoi.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcb_atoi
// decimal field converter: blanks, optional sign, digits up to first non-digit
// ----------------------------------------------------------------------------
module sdcb_atoi #(
    parameter int NDIG  = sdcb_pkg::ADDRESS_DIGITS_DEF,
    parameter int OUT_W = sdcb_pkg::ADDR_W
) (
    input  logic [NDIG-1:0][7:0] i_chars,
    output logic [OUT_W-1:0]     o_value
);
    import sdcb_pkg::*;

    always_comb begin
        t_phase           phase;
        logic [OUT_W-1:0] mag;
        logic             neg;
        logic [7:0]       c;
        phase = PH_SKIP;
        mag   = '0;
        neg   = 1'b0;
        for (int i = 0; i < NDIG; i++) begin
            c = i_chars[i];
            case (phase)
                PH_SKIP: begin
                    if (is_blank(c)) begin
                        phase = PH_SKIP;
                    end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                        neg   = (c == CHAR_MINUS);
                        phase = PH_DIGITS;
                    end else if (is_digit(c)) begin
                        mag   = {{(OUT_W-4){1'b0}}, c[3:0]};
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit(c)) begin
                        // times ten as two shifts, wraps at the field width
                        mag = (mag << 3) + (mag << 1) + {{(OUT_W-4){1'b0}}, c[3:0]};
                    end else begin
                        phase = PH_DONE;
                    end
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
        end
        o_value = neg ? (~mag + OUT_W'(1)) : mag;
    end

endmodule

// ----- design/serial_debug_command_bridge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_debug_command_bridge
// collects serial bytes into command frames and issues bus writes, bus reads
// and the transmitted reply bytes
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------
//  input   | i_in_valid / o_in_ready  | i_cmd, i_rx_byte, i_read_data
//  output  | o_out_valid / i_out_ready| o_kind, o_data_byte, o_bus_address,
//          |                          | o_last
//
// an item that only stores a byte (or is dropped) does not use the command
// slot; an item that completes a frame or returns read data occupies the slot
// until its one to three results, one per load of the single output register,
// have loaded. the next item is taken in the cycle that the slot's final result loads.
// reset clears the byte count, the pending read flag and both valid flags.
// a stall on the output holds the slot and, once it is full, the input.
// ----------------------------------------------------------------------------
module serial_debug_command_bridge #(
    parameter int ADDRESS_DIGITS = sdcb_pkg::ADDRESS_DIGITS_DEF,
    parameter int VALUE_DIGITS   = sdcb_pkg::VALUE_DIGITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic [7:0]                i_rx_byte,
    input  logic [7:0]                i_read_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic [sdcb_pkg::ADDR_W-1:0] o_bus_address,
    output logic                      o_last
);
    import sdcb_pkg::*;

    localparam int VALUE_POS = ADDR_POS + ADDRESS_DIGITS;
    localparam int FRAME_LEN = VALUE_POS + VALUE_DIGITS + 1;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);

    // frame bytes shift in at the top, byte 0 ends at index 0
    logic [FRAME_LEN-2:0][7:0] r_frame;
    logic [CNT_W-1:0]          r_count;
    logic                      r_awaiting;

    // command slot
    logic                      r_job_valid;
    t_job                      r_job;
    logic [FRAME_LEN-2:0][7:0] r_job_bytes;
    logic [7:0]                r_job_rd;
    logic [1:0]                r_idx;

    logic                      r_out_valid;
    logic [1:0]                r_out_kind;
    logic [7:0]                r_out_data;
    logic [ADDR_W-1:0]         r_out_addr;
    logic                      r_out_last;

    logic              in_fire;
    logic              out_load;
    logic              job_done;
    logic              is_frame_end;
    logic              new_job;
    logic [ADDR_W-1:0] addr_val;
    logic [VALUE_W-1:0] value_val;
    t_dir              job_dir;

    logic [1:0]        n_kind;
    logic [7:0]        n_data;
    logic [ADDR_W-1:0] n_addr;
    logic              n_last;

    sdcb_atoi #(
        .NDIG  (ADDRESS_DIGITS),
        .OUT_W (ADDR_W)
    ) u_addr_atoi (
        .i_chars (r_job_bytes[ADDR_POS +: ADDRESS_DIGITS]),
        .o_value (addr_val)
    );

    sdcb_atoi #(
        .NDIG  (VALUE_DIGITS),
        .OUT_W (VALUE_W)
    ) u_value_atoi (
        .i_chars (r_job_bytes[VALUE_POS +: VALUE_DIGITS]),
        .o_value (value_val)
    );

    assign job_dir    = dir_class(r_job_bytes[1]);
    assign out_load   = r_job_valid && (!r_out_valid || i_out_ready);
    assign job_done   = out_load && n_last;
    assign o_in_ready = !r_job_valid || job_done;
    assign in_fire    = i_in_valid && o_in_ready;

    assign is_frame_end = (r_count == LAST_CNT);
    // an item that causes results takes the slot
    assign new_job = in_fire && (
        ((i_cmd == CMD_READ_DATA) && r_awaiting) ||
        ((i_cmd == CMD_RX_BYTE) && !r_awaiting && is_frame_end));

    // result for the current slot position
    always_comb begin
        n_kind = KIND_TX;
        n_data = CHAR_CR;
        n_addr = '0;
        n_last = 1'b0;
        if (r_job == JOB_READ_DATA) begin
            case (r_idx)
                2'd0: n_data = r_job_rd;
                2'd1: n_data = CHAR_CR;
                default: begin
                    n_data = CHAR_PROMPT;
                    n_last = 1'b1;
                end
            endcase
        end else begin
            case (job_dir)
                DIR_READ: begin
                    n_kind = KIND_READ;
                    n_data = '0;
                    n_addr = addr_val;
                    n_last = 1'b1;
                end
                DIR_WRITE: begin
                    case (r_idx)
                        2'd0: begin
                            n_kind = KIND_WRITE;
                            n_data = value_val;
                            n_addr = addr_val;
                        end
                        2'd1: n_data = CHAR_CR;
                        default: begin
                            n_data = CHAR_PROMPT;
                            n_last = 1'b1;
                        end
                    endcase
                end
                default: begin
                    if (r_idx != 2'd0) begin
                        n_data = CHAR_PROMPT;
                        n_last = 1'b1;
                    end
                end
            endcase
        end
    end

    // frame collection and pending read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_awaiting <= 1'b0;
        end else if (in_fire) begin
            if (i_cmd == CMD_READ_DATA) begin
                if (r_awaiting) begin
                    r_awaiting <= 1'b0;
                end
            end else if (!r_awaiting) begin
                if (is_frame_end) begin
                    r_count <= '0;
                    if (dir_class(r_frame[1]) == DIR_READ) begin
                        r_awaiting <= 1'b1;
                    end
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_cmd == CMD_RX_BYTE) && !r_awaiting && !is_frame_end) begin
            r_frame <= {i_rx_byte, r_frame[FRAME_LEN-2:1]};
        end
    end

    // command slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (new_job) begin
                r_job_valid <= 1'b1;
                r_idx       <= '0;
            end else if (job_done) begin
                r_job_valid <= 1'b0;
                r_idx       <= '0;
            end else if (out_load) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_job) begin
            r_job       <= (i_cmd == CMD_READ_DATA) ? JOB_READ_DATA : JOB_FRAME;
            r_job_bytes <= r_frame;
            r_job_rd    <= i_read_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind <= n_kind;
            r_out_data <= n_data;
            r_out_addr <= n_addr;
            r_out_last <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_data_byte   = r_out_data;
    assign o_bus_address = r_out_addr;
    assign o_last        = r_out_last;

endmodule

// ----- test/tb_serial_debug_command_bridge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_debug_command_bridge
// drives serial bytes and read data into the bridge, predicts the bus
// requests and reply bytes in step, and checks every output item in order
// ----------------------------------------------------------------------------
module tb_serial_debug_command_bridge;

    import sdcb_pkg::*;

    localparam int VALUE_POS      = ADDR_POS + ADDRESS_DIGITS_DEF;
    localparam int FRAME_LEN      = VALUE_POS + VALUE_DIGITS_DEF + 1;
    localparam int RANDOM_ITEMS   = 120;
    // a receiver that stalls at an 86 percent idle rate never gets near this limit
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_SETTLE     = 16;
    localparam int MAX_PRINTED    = 30;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] addr;
        logic        last;
    } t_reply;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  rx;
        logic [7:0]  rd;
        logic        typed;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] addr;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = CMD_RX_BYTE;
    logic [7:0]  i_rx_byte = 8'h00;
    logic [7:0]  i_read_data = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_bus_address;
    logic        o_last;

    serial_debug_command_bridge uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_rx_byte    (i_rx_byte),
        .i_read_data  (i_read_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_bus_address(o_bus_address),
        .o_last       (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // bridge state as the predictor sees it
    logic [7:0] frame_buf [FRAME_LEN];
    int         frame_fill = 0;
    bit         read_pending = 1'b0;

    t_reply     pending_replies [$];
    int         error_count = 0;
    int         fed_items = 0;
    int         skipped_items = 0;
    int         replies_seen = 0;
    int         write_frames = 0;
    int         read_frames = 0;
    int         other_frames = 0;
    int         sender_idle_pct = 30;
    int         receiver_idle_pct = 86;
    int         idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic void push_reply(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [15:0] addr, input logic last);
        t_reply r;
        r.kind = kind;
        r.data = data;
        r.addr = addr;
        r.last = last;
        pending_replies.push_back(r);
    endfunction

    // decimal conversion of one digit group, wrapping at 16 bits
    function automatic logic [15:0] atoi_group(input int pos, input int len);
        int i;
        int mag;
        bit neg;
        logic [7:0] c;
        i = 0;
        mag = 0;
        neg = 1'b0;
        while (i < len && (frame_buf[pos + i] == CHAR_SPACE ||
               (frame_buf[pos + i] >= CHAR_TAB && frame_buf[pos + i] <= CHAR_CR))) begin
            i++;
        end
        if (i < len && (frame_buf[pos + i] == CHAR_PLUS || frame_buf[pos + i] == CHAR_MINUS)) begin
            neg = frame_buf[pos + i] == CHAR_MINUS;
            i++;
        end
        while (i < len && frame_buf[pos + i] >= CHAR_ZERO && frame_buf[pos + i] <= CHAR_NINE) begin
            c = frame_buf[pos + i] - CHAR_ZERO;
            mag = (mag * 10 + c) & 16'hFFFF;
            i++;
        end
        if (neg) begin
            mag = (-mag) & 16'hFFFF;
        end
        return mag[15:0];
    endfunction

    // advances the bridge state; returns replies queued, or -1 if the item is ignored
    function automatic int predict_replies(input logic cmd, input logic [7:0] rx,
                                           input logic [7:0] rd);
        logic [15:0] addr;
        logic [7:0]  value;
        logic [7:0]  dir;
        if (cmd == CMD_READ_DATA) begin
            if (!read_pending) begin
                return -1;
            end
            read_pending = 1'b0;
            push_reply(KIND_TX, rd, 16'h0000, 1'b0);
            push_reply(KIND_TX, CHAR_CR, 16'h0000, 1'b0);
            push_reply(KIND_TX, CHAR_PROMPT, 16'h0000, 1'b1);
            return 3;
        end
        if (read_pending) begin
            return -1;
        end
        frame_buf[frame_fill] = rx;
        frame_fill++;
        if (frame_fill < FRAME_LEN) begin
            return 0;
        end
        frame_fill = 0;
        addr  = atoi_group(ADDR_POS, ADDRESS_DIGITS_DEF);
        value = 8'(atoi_group(VALUE_POS, VALUE_DIGITS_DEF));
        dir   = frame_buf[1];
        if (dir == CHAR_R_UP || dir == CHAR_R_LO) begin
            read_frames++;
            read_pending = 1'b1;
            push_reply(KIND_READ, 8'h00, addr, 1'b1);
            return 1;
        end
        if (dir == CHAR_W_UP || dir == CHAR_W_LO) begin
            write_frames++;
            push_reply(KIND_WRITE, value, addr, 1'b0);
            push_reply(KIND_TX, CHAR_CR, 16'h0000, 1'b0);
            push_reply(KIND_TX, CHAR_PROMPT, 16'h0000, 1'b1);
            return 3;
        end
        other_frames++;
        push_reply(KIND_TX, CHAR_CR, 16'h0000, 1'b0);
        push_reply(KIND_TX, CHAR_PROMPT, 16'h0000, 1'b1);
        return 2;
    endfunction

    // holds the item until accepted, then runs the predictor on it
    task automatic send_item(input logic cmd, input logic [7:0] rx, input logic [7:0] rd,
                             output int n);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_cmd       = cmd;
        i_rx_byte   = rx;
        i_read_data = rd;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        n = predict_replies(cmd, rx, rd);
        if (n < 0) begin
            skipped_items++;
        end else begin
            fed_items++;
        end
    endtask

    task automatic drain_replies();
        while (pending_replies.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_stim_row plain(input logic cmd, input logic [7:0] rx,
                                        input logic [7:0] rd);
        t_stim_row s;
        s = '0;
        s.cmd = cmd;
        s.rx  = rx;
        s.rd  = rd;
        return s;
    endfunction

    function automatic t_stim_row typed_row(input logic cmd, input logic [7:0] rx,
                                            input logic [7:0] rd, input logic [1:0] kind,
                                            input logic [7:0] data, input logic [15:0] addr);
        t_stim_row s;
        s = plain(cmd, rx, rd);
        s.typed = 1'b1;
        s.kind  = kind;
        s.data  = data;
        s.addr  = addr;
        return s;
    endfunction

    function automatic logic [7:0] group_char();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            5: begin
                return ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                   : 8'(CHAR_TAB + $urandom_range(0, 4));
            end
            6: return CHAR_PLUS;
            7: return CHAR_MINUS;
            8: return 8'($urandom_range(0, 255));
            default: return 8'(CHAR_ZERO + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] direction_char();
        case ($urandom_range(0, 4))
            0: return CHAR_W_UP;
            1: return CHAR_W_LO;
            2: return CHAR_R_UP;
            3: return CHAR_R_LO;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // output side: random back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected reply kind %0d data 0x%02h addr 0x%04h",
                                          o_kind, o_data_byte, o_bus_address));
            end else begin
                want = pending_replies.pop_front();
                if (o_kind !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, expected %0d", o_kind, want.kind));
                end
                if (o_data_byte !== want.data) begin
                    report_mismatch($sformatf("data_byte 0x%02h, expected 0x%02h",
                                              o_data_byte, want.data));
                end
                if (o_bus_address !== want.addr) begin
                    report_mismatch($sformatf("bus_address 0x%04h, expected 0x%04h",
                                              o_bus_address, want.addr));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b", o_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row  directed_rows [$];
        t_reply     fix;
        logic [7:0] frame [FRAME_LEN];
        int         n;
        int         idx;
        int         directed_fed;
        int         phase;
        int         next_phase;

        directed_rows = '{
            // read data with no read outstanding is ignored
            plain(CMD_READ_DATA, 8'h00, 8'hFF),
            // write: address "-1" wraps to all ones, value at its maximum
            plain(CMD_RX_BYTE, 8'h00, 8'h00),
            plain(CMD_RX_BYTE, CHAR_W_UP, 8'h00),
            plain(CMD_RX_BYTE, CHAR_MINUS, 8'h00),
            plain(CMD_RX_BYTE, "1", 8'h00),
            plain(CMD_RX_BYTE, "2", 8'h00),
            plain(CMD_RX_BYTE, "5", 8'h00),
            plain(CMD_RX_BYTE, "5", 8'h00),
            typed_row(CMD_RX_BYTE, 8'hFF, 8'h00, KIND_WRITE, 8'd255, 16'hFFFF),
            // read of address 99
            plain(CMD_RX_BYTE, 8'hFF, 8'hFF),
            plain(CMD_RX_BYTE, CHAR_R_LO, 8'hFF),
            plain(CMD_RX_BYTE, "9", 8'hFF),
            plain(CMD_RX_BYTE, "9", 8'hFF),
            plain(CMD_RX_BYTE, CHAR_MINUS, 8'hFF),
            plain(CMD_RX_BYTE, "1", 8'hFF),
            plain(CMD_RX_BYTE, "2", 8'hFF),
            typed_row(CMD_RX_BYTE, 8'h00, 8'hFF, KIND_READ, 8'h00, 16'd99),
            // byte while the read is outstanding is dropped
            plain(CMD_RX_BYTE, CHAR_W_UP, 8'h00),
            typed_row(CMD_READ_DATA, 8'hFF, 8'h00, KIND_TX, 8'h00, 16'h0000),
            // unknown direction: only a CR and the prompt come back
            plain(CMD_RX_BYTE, "#", 8'h00),
            plain(CMD_RX_BYTE, "x", 8'h00),
            plain(CMD_RX_BYTE, CHAR_PLUS, 8'h00),
            plain(CMD_RX_BYTE, "7", 8'h00),
            plain(CMD_RX_BYTE, CHAR_SPACE, 8'h00),
            plain(CMD_RX_BYTE, "9", 8'h00),
            plain(CMD_RX_BYTE, "a", 8'h00),
            typed_row(CMD_RX_BYTE, 8'h0A, 8'h00, KIND_TX, CHAR_CR, 16'h0000)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].cmd, directed_rows[r].rx, directed_rows[r].rd, n);
            if (directed_rows[r].typed && n > 0) begin
                idx = pending_replies.size() - n;
                fix = pending_replies[idx];
                fix.kind = directed_rows[r].kind;
                fix.data = directed_rows[r].data;
                fix.addr = directed_rows[r].addr;
                pending_replies[idx] = fix;
            end
        end
        directed_fed = fed_items;

        phase = 0;
        while (!(fed_items - directed_fed >= RANDOM_ITEMS &&
                 frame_fill == 0 && !read_pending)) begin
            next_phase = (fed_items - directed_fed) * 3 / RANDOM_ITEMS;
            if (next_phase > 2) begin
                next_phase = 2;
            end
            if (next_phase != phase) begin
                // hold the sender off until the bridge has answered everything
                @(negedge i_clk);
                i_in_valid = 1'b0;
                drain_replies();
                phase = next_phase;
                sender_idle_pct   = (phase == 1) ? 86 : 0;
                receiver_idle_pct = (phase == 1) ? 30 : 0;
            end
            if (read_pending) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), n);
                end else begin
                    send_item(CMD_READ_DATA, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), n);
                end
            end else if (frame_fill != 0) begin
                // finish a misaligned frame with random bytes
                send_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), n);
            end else begin
                case ($urandom_range(0, 19))
                    0: send_item(CMD_READ_DATA, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), n);
                    1, 2: send_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), n);
                    default: begin
                        frame[0] = 8'($urandom_range(0, 255));
                        frame[1] = direction_char();
                        for (int k = ADDR_POS; k < FRAME_LEN - 1; k++) begin
                            frame[k] = group_char();
                        end
                        frame[FRAME_LEN - 1] = 8'($urandom_range(0, 255));
                        for (int k = 0; k < FRAME_LEN; k++) begin
                            send_item(CMD_RX_BYTE, frame[k], 8'($urandom_range(0, 255)), n);
                        end
                    end
                endcase
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        drain_replies();
        repeat (END_SETTLE) @(posedge i_clk);

        while (pending_replies.size() > 0) begin
            fix = pending_replies.pop_front();
            report_mismatch($sformatf("missing reply kind %0d data 0x%02h addr 0x%04h",
                                      fix.kind, fix.data, fix.addr));
        end

        $display("%0d items fed (%0d random), %0d ignored or dropped, %0d replies checked",
                 fed_items, fed_items - directed_fed, skipped_items, replies_seen);
        $display("frames decoded: %0d write, %0d read, %0d other direction",
                 write_frames, read_frames, other_frames);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
